/* rtl/keyed_exclusion_task_dispatcher_unit_defines.svh */
// Assertion macros used by the checker file of the dispatcher.
`ifndef KEYED_EXCLUSION_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define KEYED_EXCLUSION_TASK_DISPATCHER_UNIT_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define KETD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising clock edge, reset included.
`define KETD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ketd_pkg.sv */
package ketd_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_IN_W     = 32;
  localparam int KEY_BITS_DEF = 32;
  localparam int CFG_W        = 5;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_DONE  = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DISPATCHED = 3'd0,
    ST_THROTTLED  = 3'd1,
    ST_NONE       = 3'd2,
    ST_INLINE     = 3'd3,
    ST_CLEARED    = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_IN_W-1:0] task_key;
    logic [IDX_W-1:0]    done_index;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] dispatch_index;
    logic [CNT_W-1:0] running_now;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    append;
    logic    complete;
    logic    clear;
    logic    lim_set;
    logic    lim_en;
    logic    scan_step;
    logic    dispatch;
    logic    finish;
    status_t fin_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic add_inline;
    logic done_ok;
    logic limit_hit;
    logic scan_end;
    logic eligible;
    logic any_running;
  } dp_stat_t;

endpackage

/* rtl/ketd_dpath.sv */
module ketd_dpath
  import ketd_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dp_cmd_t          dp_cmd,
  output dp_stat_t         dp_stat,
  output logic             out_valid,
  output out_item_t        out_data
);

  logic [KEY_BITS-1:0]    key_r [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    key_in_r;
  cmd_t                   cmd_r;
  logic [IDX_W-1:0]       done_r;
  logic [TABLE_DEPTH-1:0] started_r, started_nxt;
  logic [TABLE_DEPTH-1:0] completed_r, completed_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       running_r, running_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CFG_W-1:0]       max_r;
  logic                   lim_en_r, lim_en_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic [TABLE_DEPTH-1:0] running_vec;
  logic [TABLE_DEPTH-1:0] conflict;
  logic [IDX_W-1:0]       cur;
  logic [KEY_BITS-1:0]    cur_key;

  assign running_vec = started_r & ~completed_r;
  assign cur         = idx_r[IDX_W-1:0];
  assign cur_key     = key_r[cur];

  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      conflict[j] = running_vec[j] && (key_r[j] == cur_key);
    end
  end

  always_comb begin
    dp_stat.cmd         = cmd_r;
    dp_stat.add_inline  = (max_r <= CFG_W'(1)) || (count_r >= CNT_W'(TABLE_DEPTH));
    dp_stat.done_ok     = ({1'b0, done_r} < count_r) && running_vec[done_r];
    dp_stat.limit_hit   = lim_en_r && (max_r != '0) &&
                          (32'(running_r) >= 32'(max_r));
    dp_stat.scan_end    = idx_r >= count_r;
    dp_stat.eligible    = !started_r[cur] && !(|conflict);
    dp_stat.any_running = running_r != '0;
  end

  always_comb begin
    started_nxt   = started_r;
    completed_nxt = completed_r;
    count_nxt     = count_r;
    running_nxt   = running_r;
    idx_nxt       = idx_r;
    lim_en_nxt    = lim_en_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (dp_cmd.append) begin
      started_nxt[count_r[IDX_W-1:0]]   = 1'b0;
      completed_nxt[count_r[IDX_W-1:0]] = 1'b0;
      count_nxt                         = count_r + CNT_W'(1);
    end
    if (dp_cmd.complete) begin
      completed_nxt[done_r] = 1'b1;
      running_nxt           = running_r - CNT_W'(1);
    end
    if (dp_cmd.clear) begin
      started_nxt   = '0;
      completed_nxt = '0;
      count_nxt     = '0;
      running_nxt   = '0;
    end
    if (dp_cmd.lim_set) begin
      lim_en_nxt = dp_cmd.lim_en;
      idx_nxt    = '0;
    end
    if (dp_cmd.scan_step) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (dp_cmd.dispatch) begin
      started_nxt[cur] = 1'b1;
      running_nxt      = running_r + CNT_W'(1);
    end
    if (dp_cmd.finish) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = dp_cmd.fin_status;
      out_nxt.dispatch_index = dp_cmd.dispatch ? cur : '0;
      out_nxt.running_now    = running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= '0;
      completed_r <= '0;
      count_r     <= '0;
      running_r   <= '0;
      idx_r       <= '0;
      lim_en_r    <= 1'b0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      completed_r <= completed_nxt;
      count_r     <= count_nxt;
      running_r   <= running_nxt;
      idx_r       <= idx_nxt;
      lim_en_r    <= lim_en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (dp_cmd.load) begin
      cmd_r    <= in_data.cmd;
      key_in_r <= KEY_BITS'(in_data.task_key);
      done_r   <= in_data.done_index;
    end
    if (dp_cmd.append) begin
      key_r[count_r[IDX_W-1:0]] <= key_in_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/ketd_ctrl.sv */
module ketd_ctrl
  import ketd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt         = state_r;
    dp_cmd            = '0;
    dp_cmd.fin_status = ST_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (dp_stat.cmd)
          CMD_ADD: begin
            if (dp_stat.add_inline) begin
              dp_cmd.finish     = 1'b1;
              dp_cmd.fin_status = ST_INLINE;
              state_nxt         = S_IDLE;
            end else begin
              dp_cmd.append  = 1'b1;
              dp_cmd.lim_set = 1'b1;
              dp_cmd.lim_en  = 1'b1;
              state_nxt      = S_CHECK;
            end
          end
          CMD_DONE: begin
            if (dp_stat.done_ok) begin
              dp_cmd.complete = 1'b1;
              dp_cmd.lim_set  = 1'b1;
              state_nxt       = S_CHECK;
            end else begin
              dp_cmd.finish     = 1'b1;
              dp_cmd.fin_status = ST_NONE;
              state_nxt         = S_IDLE;
            end
          end
          CMD_POLL: begin
            dp_cmd.lim_set = 1'b1;
            dp_cmd.lim_en  = 1'b1;
            state_nxt      = S_CHECK;
          end
          CMD_CLEAR: begin
            dp_cmd.clear      = 1'b1;
            dp_cmd.finish     = 1'b1;
            dp_cmd.fin_status = ST_CLEARED;
            state_nxt         = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CHECK: begin
        if (dp_stat.limit_hit) begin
          dp_cmd.finish     = 1'b1;
          dp_cmd.fin_status = ST_THROTTLED;
          state_nxt         = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (dp_stat.scan_end) begin
          dp_cmd.finish     = 1'b1;
          dp_cmd.fin_status = dp_stat.any_running ? ST_THROTTLED : ST_NONE;
          state_nxt         = S_IDLE;
        end else if (dp_stat.eligible) begin
          dp_cmd.dispatch   = 1'b1;
          dp_cmd.finish     = 1'b1;
          dp_cmd.fin_status = ST_DISPATCHED;
          state_nxt         = S_IDLE;
        end else begin
          dp_cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

/* rtl/keyed_exclusion_task_dispatcher_unit.sv */
// Keyed exclusion task dispatcher.
// A request is taken at a rising edge with start high and busy low; in_data
// carries the command, the task key and the finished table position.
// Each request yields exactly one result on out_data, shown for one cycle
// with out_valid high; the receiver cannot stall it.
// The user must write the limit register through cfg_we and cfg_wdata
// while idle; the block itself does not enforce it. A clear, a run-inline
// add or a rejected completion is decided in the S_EXEC state, its result
// is registered, and busy drops in the same cycle as it is shown. A request
// held at the limit is decided in S_CHECK, after S_EXEC. Otherwise the
// dispatch scan walks the table one entry per cycle after S_CHECK, oldest
// first, comparing the entry's key with all running keys at once.
// A new request may be accepted in the cycle the previous result is shown.
// Reset empties the table, clears the limit to zero and drops busy;
// no clearing pass is needed.
module keyed_exclusion_task_dispatcher_unit
  import ketd_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ketd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd)
  );

  ketd_dpath #(
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/ketd_checker.sv */
`include "keyed_exclusion_task_dispatcher_unit_defines.svh"

module ketd_checker
  import ketd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  `KETD_ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "Accepted request did not raise busy")
  `KETD_ASSERT_CLK(a_strobe_single, out_valid |=> !out_valid, "Result strobe held two cycles")
  `KETD_ASSERT_CLK(a_busy_result, $fell(busy) |-> out_valid, "Busy dropped without a result")
  `KETD_ASSERT_ALWAYS(a_index_zero,
    out_valid && out_data.status != ST_DISPATCHED |-> out_data.dispatch_index == '0,
    "Index set without a dispatch")

endmodule

bind keyed_exclusion_task_dispatcher_unit ketd_checker u_ketd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
